// ===== hdl/smavg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smavg_pkg
// shared widths, microcode encodings, control program and helper functions
// for the segment throughput moving average block
// ----------------------------------------------------------------------------
package smavg_pkg;

  // field widths
  localparam int IDX_W  = 16;
  localparam int BYTE_W = 24;
  localparam int TIME_W = 48;
  localparam int EST_W  = 47;
  localparam int CASE_W = 2;

  // history window
  localparam int WINDOW = 5;
  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);

  // rate arithmetic: bits = bytes * 1e6 * 8
  localparam int US_W       = 20;
  localparam int PROD_W     = BYTE_W + US_W;
  localparam int BYTE_SHIFT = 3;
  localparam logic [US_W-1:0] US_PER_S = US_W'(1000000);

  // shared divider: dividend wide enough for the window sum
  localparam int SUM_W  = EST_W + SLOT_W;
  localparam int DIV_ITERS = SUM_W;
  localparam int ITER_W = $clog2(DIV_ITERS);

  // decision codes
  localparam logic [CASE_W-1:0] CASE_FIRST   = 2'd0;
  localparam logic [CASE_W-1:0] CASE_PARTIAL = 2'd1;
  localparam logic [CASE_W-1:0] CASE_FULL    = 2'd2;

  // datapath operations
  typedef logic [3:0] op_t;
  localparam op_t OP_NOP   = 4'd0;
  localparam op_t OP_LOAD  = 4'd1;
  localparam op_t OP_RATE  = 4'd2;
  localparam op_t OP_DIV   = 4'd3;
  localparam op_t OP_STORE = 4'd4;
  localparam op_t OP_ACC   = 4'd5;
  localparam op_t OP_MEAN  = 4'd6;
  localparam op_t OP_OUT   = 4'd7;
  localparam op_t OP_OUTZ  = 4'd8;

  // jump conditions
  typedef logic [2:0] cond_t;
  localparam cond_t C_NEVER   = 3'd0;
  localparam cond_t C_NOACC   = 3'd1;
  localparam cond_t C_IDXZ    = 3'd2;
  localparam cond_t C_CNTNZ   = 3'd3;
  localparam cond_t C_MORE    = 3'd4;
  localparam cond_t C_OUTFULL = 3'd5;

  // program steps
  typedef logic [3:0] step_t;
  localparam step_t S_WAIT  = 4'd0;
  localparam step_t S_CHK   = 4'd1;
  localparam step_t S_RATE  = 4'd2;
  localparam step_t S_RDIV  = 4'd3;
  localparam step_t S_STORE = 4'd4;
  localparam step_t S_ACC   = 4'd5;
  localparam step_t S_MLOAD = 4'd6;
  localparam step_t S_MDIV  = 4'd7;
  localparam step_t S_OUT   = 4'd8;
  localparam step_t S_ZERO  = 4'd9;
  localparam step_t S_LAST  = S_ZERO;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
    logic  fin;     // fall through to the wait step instead of step + 1
  } ctrl_t;

  typedef struct packed {
    logic idx_zero;
    logic cnt_nz;
    logic acc_more;
    logic win_full;
  } dp_flags_t;

  typedef struct packed {
    logic      accept;
    logic      out_full;
    dp_flags_t dp;
  } status_t;

  // control store
  function automatic ctrl_t ucode_rom(input step_t step);
    ctrl_t cw;
    cw = '{op: OP_NOP, cond: C_NEVER, target: S_WAIT, fin: 1'b1};
    case (step)
      S_WAIT:  cw = '{op: OP_LOAD,  cond: C_NOACC,   target: S_WAIT,  fin: 1'b0};
      S_CHK:   cw = '{op: OP_NOP,   cond: C_IDXZ,    target: S_ZERO,  fin: 1'b0};
      S_RATE:  cw = '{op: OP_RATE,  cond: C_NEVER,   target: S_WAIT,  fin: 1'b0};
      S_RDIV:  cw = '{op: OP_DIV,   cond: C_CNTNZ,   target: S_RDIV,  fin: 1'b0};
      S_STORE: cw = '{op: OP_STORE, cond: C_NEVER,   target: S_WAIT,  fin: 1'b0};
      S_ACC:   cw = '{op: OP_ACC,   cond: C_MORE,    target: S_ACC,   fin: 1'b0};
      S_MLOAD: cw = '{op: OP_MEAN,  cond: C_NEVER,   target: S_WAIT,  fin: 1'b0};
      S_MDIV:  cw = '{op: OP_DIV,   cond: C_CNTNZ,   target: S_MDIV,  fin: 1'b0};
      S_OUT:   cw = '{op: OP_OUT,   cond: C_OUTFULL, target: S_OUT,   fin: 1'b1};
      S_ZERO:  cw = '{op: OP_OUTZ,  cond: C_OUTFULL, target: S_ZERO,  fin: 1'b1};
      default: cw = '{op: OP_NOP,   cond: C_NEVER,   target: S_WAIT,  fin: 1'b1};
    endcase
    return cw;
  endfunction

  // clamp a divider result to the estimate field
  function automatic logic [EST_W-1:0] sat_est(input logic [SUM_W-1:0] v);
    if (|v[SUM_W-1:EST_W]) begin
      return '1;
    end
    return v[EST_W-1:0];
  endfunction

endpackage

// ===== hdl/smavg_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smavg_seq
// step counter and control store; picks the next step from the jump
// condition of the current control word
// ----------------------------------------------------------------------------
module smavg_seq
  import smavg_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  status_t status,
  output op_t     op,
  output logic    idle
);

  step_t step_r;
  step_t step_nxt;
  ctrl_t cw;
  logic  take;

  assign cw   = ucode_rom(step_r);
  assign op   = cw.op;
  assign idle = (step_r == S_WAIT);

  always_comb begin
    case (cw.cond)
      C_NEVER:   take = 1'b0;
      C_NOACC:   take = !status.accept;
      C_IDXZ:    take = status.dp.idx_zero;
      C_CNTNZ:   take = status.dp.cnt_nz;
      C_MORE:    take = status.dp.acc_more;
      C_OUTFULL: take = status.out_full;
      default:   take = 1'b0;
    endcase
  end

  always_comb begin
    if (take) begin
      step_nxt = cw.target;
    end else if (cw.fin) begin
      step_nxt = S_WAIT;
    end else begin
      step_nxt = step_r + step_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_WAIT;
    end else begin
      step_r <= step_nxt;
    end
  end

  // the program counter stays inside the control store
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= S_LAST)
    else $error("step counter left the program");

endmodule

// ===== hdl/smavg_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smavg_dp
// datapath: operand latches, rate multiplier, shared restoring divider,
// throughput history ring and window accumulator
// ----------------------------------------------------------------------------
module smavg_dp
  import smavg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  op_t               op,
  input  logic              accept,
  input  logic [IDX_W-1:0]  in_segment_index,
  input  logic [BYTE_W-1:0] in_segment_bytes,
  input  logic [TIME_W-1:0] in_start_time_us,
  input  logic [TIME_W-1:0] in_end_time_us,
  output dp_flags_t         flags,
  output logic [EST_W-1:0]  result
);

  // operand latches
  logic              idx_zero_r;
  logic [BYTE_W-1:0] bytes_r;
  logic [TIME_W-1:0] start_r;
  logic [TIME_W-1:0] end_r;

  // divider
  logic [SUM_W-1:0]  q_r;
  logic [TIME_W-1:0] r_r;
  logic [TIME_W-1:0] d_r;
  logic [ITER_W-1:0] iter_r;

  // history and window sum
  logic [EST_W-1:0]  hist [WINDOW];
  logic [CNT_W-1:0]  cnt_r;
  logic [SLOT_W-1:0] slot_r;
  logic [SLOT_W-1:0] rd_r;
  logic [SUM_W-1:0]  sum_r;

  logic [PROD_W-1:0] prod;
  logic [EST_W-1:0]  bits;
  logic [TIME_W-1:0] dur;
  logic [TIME_W-1:0] dvsr;
  logic [TIME_W:0]   rs;
  logic [TIME_W:0]   diff;
  logic              ge;
  logic [CNT_W-1:0]  rd_inc;
  logic [EST_W-1:0]  rate_sat;

  assign prod = PROD_W'(bytes_r) * PROD_W'(US_PER_S);
  assign bits = {prod, BYTE_SHIFT'(0)};
  assign dur  = end_r - start_r;
  assign dvsr = (dur == '0) ? TIME_W'(1) : dur;

  // one restoring step
  assign rs   = {r_r, q_r[SUM_W-1]};
  assign diff = rs - {1'b0, d_r};
  assign ge   = (rs >= {1'b0, d_r});

  assign rd_inc   = CNT_W'(rd_r) + CNT_W'(1);
  assign rate_sat = sat_est(q_r);
  assign result   = rate_sat;

  assign flags.idx_zero = idx_zero_r;
  assign flags.cnt_nz   = (iter_r != '0);
  assign flags.acc_more = (rd_inc < cnt_r);
  assign flags.win_full = (cnt_r == CNT_W'(WINDOW));

  // payload registers
  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        if (accept) begin
          idx_zero_r <= (in_segment_index == '0);
          bytes_r    <= in_segment_bytes;
          start_r    <= in_start_time_us;
          end_r      <= in_end_time_us;
        end
      end
      OP_RATE: begin
        q_r <= SUM_W'(bits);
        r_r <= '0;
        d_r <= dvsr;
      end
      OP_DIV: begin
        q_r <= {q_r[SUM_W-2:0], ge};
        r_r <= ge ? diff[TIME_W-1:0] : rs[TIME_W-1:0];
      end
      OP_STORE: begin
        hist[slot_r] <= rate_sat;
        sum_r        <= '0;
        rd_r         <= '0;
      end
      OP_ACC: begin
        sum_r <= sum_r + SUM_W'(hist[rd_r]);
        rd_r  <= rd_inc[SLOT_W-1:0];
      end
      OP_MEAN: begin
        q_r <= sum_r;
        r_r <= '0;
        d_r <= TIME_W'(cnt_r);
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      slot_r <= '0;
      iter_r <= '0;
    end else begin
      case (op)
        OP_RATE, OP_MEAN: iter_r <= ITER_W'(DIV_ITERS - 1);
        OP_DIV:           iter_r <= iter_r - ITER_W'(1);
        OP_STORE: begin
          slot_r <= (slot_r == SLOT_W'(WINDOW - 1)) ? '0 : slot_r + SLOT_W'(1);
          if (cnt_r < CNT_W'(WINDOW)) begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // fill level and write slot stay in range
  a_ring_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(WINDOW) && CNT_W'(slot_r) < CNT_W'(WINDOW))
    else $error("history ring pointers out of range");

  // until the window fills, the ring writes the next free slot
  a_fill_order: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < CNT_W'(WINDOW) |-> CNT_W'(slot_r) == cnt_r)
    else $error("write slot out of step with fill level");

endmodule

// ===== hdl/segment_throughput_moving_average.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_throughput_moving_average
// per-segment throughput (8 * bytes * 1e6 / duration) averaged over the
// last WINDOW segments, run by a microcoded sequencer over a shared divider
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake          payload
//  in_      input      in_valid/in_stall  segment_index, segment_bytes,
//                                         start_time_us, end_time_us
//  out_     output     out_valid/out_stall estimate_bps, decision_case
//
//  a segment with nonzero index runs two 50-step passes of the one restoring
//  divider, one for its rate and one for the mean of the values in the window
//  (up to 5), before its result register is loaded; a segment with index zero
//  skips the divider and goes straight to the result register
//  in_stall is high from acceptance until the program returns to its wait step
//  synchronous active-low reset clears the program counter, fill level, write
//  slot and result valid; history contents are not cleared
//  a stalled result holds the program at its output step
//
module segment_throughput_moving_average
  import smavg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [IDX_W-1:0]  in_segment_index,
  input  logic [BYTE_W-1:0] in_segment_bytes,
  input  logic [TIME_W-1:0] in_start_time_us,
  input  logic [TIME_W-1:0] in_end_time_us,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [EST_W-1:0]  out_estimate_bps,
  output logic [CASE_W-1:0] out_decision_case
);

  op_t              op;
  logic             idle;
  logic             accept;
  status_t          status;
  dp_flags_t        flags;
  logic [EST_W-1:0] result;

  // result register
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [EST_W-1:0]  est_r;
  logic [CASE_W-1:0] case_r;
  logic              out_full;
  logic              out_load;

  // the program only takes a transaction at its wait step
  assign in_stall = !idle;
  assign accept   = in_valid && idle;

  // result register busy: still holding an unread transaction
  assign out_full = out_valid_r && out_stall;
  assign out_load = ((op == OP_OUT) || (op == OP_OUTZ)) && !out_full;

  assign status.accept   = accept;
  assign status.out_full = out_full;
  assign status.dp       = flags;

  smavg_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .op     (op),
    .idle   (idle)
  );

  smavg_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .op               (op),
    .accept           (accept),
    .in_segment_index (in_segment_index),
    .in_segment_bytes (in_segment_bytes),
    .in_start_time_us (in_start_time_us),
    .in_end_time_us   (in_end_time_us),
    .flags            (flags),
    .result           (result)
  );

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // estimate and decision, zero for a first-segment report
  always_ff @(posedge clk) begin
    if (out_load) begin
      if (op == OP_OUTZ) begin
        est_r  <= '0;
        case_r <= CASE_FIRST;
      end else begin
        est_r  <= result;
        case_r <= flags.win_full ? CASE_FULL : CASE_PARTIAL;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_estimate_bps  = est_r;
  assign out_decision_case = case_r;

  // one item at a time: a taken transaction closes the input
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("input still open after a transaction");

  // a first-segment report always carries a zero estimate
  a_first_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_decision_case == CASE_FIRST |-> out_estimate_bps == '0)
    else $error("first-segment result with nonzero estimate");

  // a result is never loaded over one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_full |-> !out_load)
    else $error("result register overwritten while stalled");

endmodule

// ===== test/tb_segment_throughput_moving_average.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_segment_throughput_moving_average
// self-checking bench for the segment throughput moving average block: a
// directed pass over the corner cases, then random segments under bursty
// input pacing, output stall patterns, a long output hold-off and drain
// pauses, each result checked field by field against an in-bench estimator
// ----------------------------------------------------------------------------
module tb_segment_throughput_moving_average
  import smavg_pkg::*;
();

  // 2^47 - 1, the saturation point of one rate and of the mean
  localparam logic [63:0] EST_MAX = 64'h0000_7FFF_FFFF_FFFF;
  // eight bits per byte times one million microseconds per second
  localparam logic [63:0] BIT_US_PER_BYTE = 64'd8_000_000;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  // two divider passes plus the window walk and some slack
  localparam int RESULT_LATENCY = 2 * SUM_W + 2 * WINDOW + 3 + 20;
  localparam int DRAIN_LIMIT = 50_000;
  localparam int REPORT_LIMIT = 10;

  typedef struct {
    logic [EST_W-1:0]  estimate;
    logic [CASE_W-1:0] dcase;
  } estimate_t;

  // receiver behavior outside a hold-off
  typedef enum logic {STALL_NONE, STALL_PATTERN} stall_mode_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [IDX_W-1:0]  in_segment_index = '0;
  logic [BYTE_W-1:0] in_segment_bytes = '0;
  logic [TIME_W-1:0] in_start_time_us = '0;
  logic [TIME_W-1:0] in_end_time_us = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [EST_W-1:0]  out_estimate_bps;
  logic [CASE_W-1:0] out_decision_case;

  segment_throughput_moving_average dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_segment_index  (in_segment_index),
    .in_segment_bytes  (in_segment_bytes),
    .in_start_time_us  (in_start_time_us),
    .in_end_time_us    (in_end_time_us),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_estimate_bps  (out_estimate_bps),
    .out_decision_case (out_decision_case)
  );

  always #5 clk = ~clk;

  // estimator state, a private copy of the window history
  logic [EST_W-1:0] rate_history [WINDOW];
  int unsigned      stored_count = 0;
  int unsigned      next_slot = 0;

  // estimates waiting for their result transaction, oldest first
  estimate_t pending_estimates[$];
  estimate_t oldest_estimate;
  int        mismatch_count = 0;

  // sender pacing knobs
  bit          sender_gaps = 1'b0;
  int          burst_left = 0;

  // receiver knobs; a hold-off is asked for by bumping the request count
  stall_mode_t stall_mode = STALL_NONE;
  int          holdoff_cycles = 0;
  int          holdoff_requests = 0;
  int          holdoff_served = 0;
  int          holdoff_left = 0;
  logic [15:0] stall_pattern = '0;
  int          stall_phase = 0;

  task automatic report_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("%t: %s", $realtime, msg);
    end
  endtask

  // bits per second of one segment, truncated and clamped to the field
  function automatic logic [EST_W-1:0] segment_rate_bps(input logic [BYTE_W-1:0] bytes,
                                                        input logic [TIME_W-1:0] start,
                                                        input logic [TIME_W-1:0] stop);
    logic [TIME_W-1:0] span;
    logic [63:0]       bits;
    logic [63:0]       rate;
    // a 48 bit subtract, so end before start wraps around
    span = stop - start;
    // a zero duration counts as one microsecond
    if (span == '0) begin
      span = TIME_W'(1);
    end
    bits = 64'(bytes) * BIT_US_PER_BYTE;
    rate = bits / 64'(span);
    if (rate > EST_MAX) begin
      rate = EST_MAX;
    end
    return rate[EST_W-1:0];
  endfunction

  // advance the private history by one accepted segment and queue its estimate
  task automatic record_segment(input logic [IDX_W-1:0]  idx,
                                input logic [BYTE_W-1:0] bytes,
                                input logic [TIME_W-1:0] start,
                                input logic [TIME_W-1:0] stop);
    estimate_t   next_est;
    logic [63:0] sum;
    logic [63:0] mean;
    if (idx == '0) begin
      // first segment of a stream: nothing stored, estimate zero
      next_est.estimate = '0;
      next_est.dcase    = CASE_FIRST;
    end else begin
      rate_history[next_slot] = segment_rate_bps(bytes, start, stop);
      next_slot = (next_slot == WINDOW - 1) ? 0 : next_slot + 1;
      if (stored_count < WINDOW) begin
        stored_count++;
      end
      sum = '0;
      for (int i = 0; i < stored_count; i++) begin
        sum += 64'(rate_history[i]);
      end
      mean = sum / 64'(stored_count);
      if (mean > EST_MAX) begin
        mean = EST_MAX;
      end
      next_est.estimate = mean[EST_W-1:0];
      // the store that fills the window already reports a full window
      next_est.dcase    = (stored_count < WINDOW) ? CASE_PARTIAL : CASE_FULL;
    end
    pending_estimates.insert(pending_estimates.size(), next_est);
  endtask

  // after a transaction: stay in the burst or drop valid for a random gap
  task automatic pace_sender();
    int gap;
    if (!sender_gaps) begin
      return;
    end
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    // mostly short gaps, now and then a long one that can outlast a whole computation
    gap = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 160) : $urandom_range(1, 10);
    in_valid <= 1'b0;
    repeat (gap) @(posedge clk);
    burst_left = $urandom_range(0, 10);
  endtask

  // offer one segment and hold it until the block takes it
  task automatic send_segment(input logic [IDX_W-1:0]  idx,
                              input logic [BYTE_W-1:0] bytes,
                              input logic [TIME_W-1:0] start,
                              input logic [TIME_W-1:0] stop);
    in_valid         <= 1'b1;
    in_segment_index <= idx;
    in_segment_bytes <= bytes;
    in_start_time_us <= start;
    in_end_time_us   <= stop;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    record_segment(idx, bytes, start, stop);
    pace_sender();
  endtask

  // random segment with durations spread over many decades
  task automatic send_random_segment();
    logic [IDX_W-1:0]  idx;
    logic [BYTE_W-1:0] bytes;
    logic [TIME_W-1:0] start;
    logic [TIME_W-1:0] span;
    logic [63:0]       raw;
    // about one in ten starts a new stream
    idx = ($urandom_range(0, 9) == 0) ? '0 : IDX_W'($urandom_range(1, 65535));
    case ($urandom_range(0, 7))
      0:       bytes = BYTE_W'($urandom);
      1:       bytes = BYTE_W'($urandom_range(0, 255));
      2:       bytes = $urandom_range(0, 1) ? '1 : '0;
      default: bytes = BYTE_W'($urandom_range(200_000, 8_000_000));
    endcase
    raw = {$urandom, $urandom};
    start = ($urandom_range(0, 5) == 0) ? TIME_MAX - TIME_W'($urandom_range(0, 1000))
                                        : raw[TIME_W-1:0];
    raw = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0:       span = '0;
      1, 2:    span = TIME_W'($urandom_range(1, 1000));
      3, 4, 5: span = TIME_W'($urandom_range(1000, 30_000_000));
      6:       span = raw[TIME_W-1:0];
      // end a little before start
      7:       span = '0 - TIME_W'($urandom_range(1, 5000));
      default: span = TIME_W'($urandom_range(100_000, 10_000_000));
    endcase
    send_segment(idx, bytes, start, start + span);
  endtask

  // drop valid and wait until every estimate has come back
  task automatic wait_for_estimates();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_estimates.size() != 0) @(posedge clk);
  endtask

  // receiver: a long hold-off when asked, otherwise its own stall pattern
  always @(posedge clk) begin
    if (holdoff_served != holdoff_requests) begin
      holdoff_served = holdoff_requests;
      holdoff_left   = holdoff_cycles;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      out_stall <= 1'b1;
    end else if (stall_mode == STALL_NONE) begin
      out_stall <= 1'b0;
    end else begin
      // fresh pattern each time the phase counter wraps: clear, sparse or dense
      if (stall_phase == 0) begin
        case ($urandom_range(0, 3))
          0:       stall_pattern = '0;
          1:       stall_pattern = 16'($urandom & $urandom);
          default: stall_pattern = 16'($urandom);
        endcase
      end
      out_stall <= stall_pattern[0];
      stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
      stall_phase = (stall_phase + 1) % 48;
    end
  end

  // result checker: every transaction against the oldest pending estimate
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_estimates.size() == 0) begin
        report_error($sformatf("unexpected result: estimate %0d case %0d",
                               out_estimate_bps, out_decision_case));
      end else begin
        oldest_estimate = pending_estimates.pop_front();
        if (out_estimate_bps !== oldest_estimate.estimate) begin
          report_error($sformatf("estimate_bps mismatch: expected %0d got %0d",
                                 oldest_estimate.estimate, out_estimate_bps));
        end
        if (out_decision_case !== oldest_estimate.dcase) begin
          report_error($sformatf("decision_case mismatch: expected %0d got %0d",
                                 oldest_estimate.dcase, out_decision_case));
        end
      end
    end
  end

  // corner cases, in order so the window fills, wraps and runs at its largest rate
  task automatic test_directed();
    sender_gaps = 1'b0;
    stall_mode  = STALL_NONE;
    // zero index on an empty history
    send_segment(16'd0, 24'hFF_FFFF, 48'd0, 48'd1000);
    // exactly one megabit per second
    send_segment(16'd1, 24'd1_000_000, 48'd0, 48'd8_000_000);
    // zero duration with the largest size, all times at their maximum
    send_segment(16'hFFFF, 24'hFF_FFFF, TIME_MAX, TIME_MAX);
    // end before start, empty segment
    send_segment(16'd2, 24'd0, 48'd5, 48'd3);
    // zero index in the middle of filling, history must stay put
    send_segment(16'd0, 24'd12345, 48'd7, 48'd9);
    // longest possible duration
    send_segment(16'h8000, 24'hFF_FFFF, 48'd0, TIME_MAX);
    // end wraps past start by one microsecond, this store fills the window
    send_segment(16'd3, 24'd1, TIME_MAX, 48'd0);
    // overwrite the oldest entries
    send_segment(16'd4, 24'h80_0000, 48'h8000_0000_0000, 48'h8000_001E_8480);
    send_segment(16'd5, 24'h7F_FFFF, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000);
    send_segment(16'd0, 24'h00_0001, 48'h0000_0000_0001, 48'h0000_0000_0000);
    // whole window at the largest rate
    repeat (WINDOW) send_segment(16'h5555, 24'hFF_FFFF, 48'hAAAA_AAAA_AAAA,
                                 48'hAAAA_AAAA_AAAA);
    send_segment(16'hAAAA, 24'h55_5555, 48'h5555_5555_5555, 48'h5555_5555_D555);
    send_segment(16'h0001, 24'h00_0001, 48'd0, TIME_MAX);
    wait_for_estimates();
  endtask

  // bursty sender against the stall pattern
  task automatic test_random_traffic(input int count);
    sender_gaps = 1'b1;
    stall_mode  = STALL_PATTERN;
    repeat (count) send_random_segment();
  endtask

  // receiver holds off while the sender keeps offering back to back
  task automatic test_output_holdoff();
    sender_gaps      = 1'b0;
    stall_mode       = STALL_NONE;
    holdoff_cycles   = 400;
    holdoff_requests = holdoff_requests + 1;
    repeat (12) send_random_segment();
  endtask

  // sender stops until all estimates are back, then starts again from idle
  task automatic test_drain_pause();
    sender_gaps = 1'b1;
    stall_mode  = STALL_PATTERN;
    repeat (3) begin
      repeat (8) send_random_segment();
      wait_for_estimates();
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  endtask

  // no idling on either side
  task automatic test_steady_stream(input int count);
    sender_gaps = 1'b0;
    stall_mode  = STALL_NONE;
    repeat (count) send_random_segment();
  endtask

  initial begin
    int drain_wait;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_traffic(250);
    test_output_holdoff();
    test_drain_pause();
    test_steady_stream(100);
    test_random_traffic(200);

    // let the last results come home, then watch for strays
    stall_mode = STALL_PATTERN;
    in_valid <= 1'b0;
    drain_wait = 0;
    while (pending_estimates.size() != 0 && drain_wait < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_wait++;
    end
    repeat (RESULT_LATENCY) @(posedge clk);
    if (pending_estimates.size() != 0) begin
      report_error($sformatf("%0d estimates never arrived", pending_estimates.size()));
    end
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
